// File: sv/track_history_median_smoother_defines.svh
// Assertion helpers for the track history median smoother.
`ifndef TRACK_HISTORY_MEDIAN_SMOOTHER_DEFINES_SVH
`define TRACK_HISTORY_MEDIAN_SMOOTHER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define THMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define THMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/thms_pkg.sv
`default_nettype none

package thms_pkg;

  // Miss counter and limit register width.
  localparam int MISS_W = 5;

  typedef logic [MISS_W-1:0] miss_cnt_t;

  // Empty or missed history entry: -1000.0 m in Q15.8.
  localparam int SENTINEL_Q8 = -256000;
  // Signed bits needed to hold the sentinel.
  localparam int SENT_W = 19;

  localparam miss_cnt_t MISS_MAX         = 5'd31;
  localparam miss_cnt_t MISS_LIMIT_RESET = 5'd5;

endpackage

`default_nettype wire

// File: sv/thms_if.sv
`default_nettype none

// Frame outcome channel.
interface thms_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic                          start_track;
  logic                          detected;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;

  modport source (output valid, start_track, detected, pos_x, pos_y, input ready);
  modport sink   (input valid, start_track, detected, pos_x, pos_y, output ready);
endinterface

// Smoothed position channel.
interface thms_out_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] median_x;
  logic signed [COORD_WIDTH-1:0] median_y;
  logic                          median_valid;
  logic                          expired;

  modport source (output valid, median_x, median_y, median_valid, expired, input ready);
  modport sink   (input valid, median_x, median_y, median_valid, expired, output ready);
endinterface

`default_nettype wire

// File: sv/track_history_median_smoother.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    start_track, detected, pos_x, pos_y
// out_ch    out  valid/ready    median_x, median_y, median_valid, expired
// cfg       in   cfg_we         cfg_wdata = miss_limit
//
// One transaction per cycle sustained while out_ch.ready stays high; the input register
// feeds the result register, with history update, rank-count median and expiry in between.
// rst_n is synchronous: history goes to -1000.0 m, misses to 0, limit to 5.
// A stalled result holds the result register; the input register still takes
// one more transaction, then in_ch.ready drops until out_ch.ready returns.
`default_nettype none

module track_history_median_smoother #(
  parameter int HISTORY_DEPTH = 5,
  parameter int COORD_WIDTH   = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  thms_in_if.sink                        in_ch,
  thms_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [thms_pkg::MISS_W-1:0] cfg_wdata
);
  import thms_pkg::*;

  // Storage is wide enough for both the coordinates and the sentinel.
  localparam int SW    = (COORD_WIDTH > SENT_W) ? COORD_WIDTH : SENT_W;
  localparam int MID   = HISTORY_DEPTH / 2;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic signed [SW-1:0] SENT = SW'(SENTINEL_Q8);

  typedef logic signed [SW-1:0] hist_t [HISTORY_DEPTH];

  // Element MID of the sorted values, by rank counting.
  function automatic logic signed [SW-1:0] median_of(input hist_t v);
    logic [CNT_W-1:0]        less;
    logic [CNT_W-1:0]        eq;
    logic                    found;
    logic signed [SW-1:0]    res;
    res   = v[0];
    found = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      less = '0;
      eq   = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if (v[j] < v[i]) begin
          less = less + CNT_W'(1);
        end else if (v[j] == v[i]) begin
          eq = eq + CNT_W'(1);
        end
      end
      if (!found && (less <= CNT_W'(MID)) &&
          (({1'b0, less} + {1'b0, eq}) > (CNT_W + 1)'(MID))) begin
        res   = v[i];
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // Configuration
  miss_cnt_t cfg_limit_r;

  // Input register
  logic                          a_vld_r;
  logic                          a_start_r;
  logic                          a_det_r;
  logic signed [COORD_WIDTH-1:0] a_px_r;
  logic signed [COORD_WIDTH-1:0] a_py_r;

  // Track state
  hist_t     hist_x_r;
  hist_t     hist_y_r;
  miss_cnt_t miss_r;

  // Result register
  logic                          out_vld_r;
  logic signed [COORD_WIDTH-1:0] out_mx_r;
  logic signed [COORD_WIDTH-1:0] out_my_r;
  logic                          out_mvld_r;
  logic                          out_exp_r;

  logic in_rdy;
  logic in_fire;
  logic a_fire;

  logic signed [SW-1:0] px_ext;
  logic signed [SW-1:0] py_ext;
  logic signed [SW-1:0] nx;
  logic signed [SW-1:0] ny;
  hist_t                shift_x;
  hist_t                shift_y;
  logic signed [SW-1:0] med_x;
  logic signed [SW-1:0] med_y;
  logic                 miss_c;
  miss_cnt_t            miss_base;
  miss_cnt_t            miss_nxt;
  logic                 exp_c;

  assign a_fire  = a_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy  = !a_vld_r || a_fire;
  assign in_fire = in_ch.valid && in_rdy;

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.median_x     = out_mx_r;
  assign out_ch.median_y     = out_my_r;
  assign out_ch.median_valid = out_mvld_r;
  assign out_ch.expired      = out_exp_r;

  assign px_ext = SW'(a_px_r);
  assign py_ext = SW'(a_py_r);

  always_comb begin
    // A start frame is a detection on a freshly seeded history.
    nx = (a_start_r || a_det_r) ? px_ext : SENT;
    ny = (a_start_r || a_det_r) ? py_ext : SENT;
    miss_c    = (nx == SENT) || (ny == SENT);
    miss_base = a_start_r ? '0 : miss_r;
    if (!miss_c) begin
      miss_nxt = '0;
    end else if (miss_base == MISS_MAX) begin
      miss_nxt = miss_base;
    end else begin
      miss_nxt = miss_base + MISS_W'(1);
    end

    shift_x[0] = nx;
    shift_y[0] = ny;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      if (a_start_r) begin
        shift_x[i] = (i == 1) ? px_ext : SENT;
        shift_y[i] = (i == 1) ? py_ext : SENT;
      end else begin
        shift_x[i] = hist_x_r[i-1];
        shift_y[i] = hist_y_r[i-1];
      end
    end

    med_x = median_of(shift_x);
    med_y = median_of(shift_y);
    exp_c = miss_nxt > cfg_limit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= MISS_LIMIT_RESET;
    end else if (cfg_we) begin
      cfg_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_fire) begin
      a_vld_r <= 1'b1;
    end else if (a_fire) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_start_r <= in_ch.start_track;
      a_det_r   <= in_ch.detected;
      a_px_r    <= in_ch.pos_x;
      a_py_r    <= in_ch.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_x_r[i] <= SENT;
        hist_y_r[i] <= SENT;
      end
      miss_r <= '0;
    end else if (a_fire) begin
      // Drop the track on expiry, after its median has been taken.
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_x_r[i] <= exp_c ? SENT : shift_x[i];
        hist_y_r[i] <= exp_c ? SENT : shift_y[i];
      end
      miss_r <= exp_c ? '0 : miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (a_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_mx_r   <= COORD_WIDTH'(med_x);
      out_my_r   <= COORD_WIDTH'(med_y);
      out_mvld_r <= (med_x != SENT) && (med_y != SENT);
      out_exp_r  <= exp_c;
    end
  end

  `include "track_history_median_smoother_defines.svh"

  `THMS_ASSERT_NOW(a_ready_low_only_when_full, !in_rdy, a_vld_r && out_vld_r && !out_ch.ready, "input held back while a stage is free")
  `THMS_ASSERT_NEXT(a_expiry_clears_track, a_fire && exp_c, (miss_r == '0) && (hist_x_r[0] == SENT) && (hist_y_r[HISTORY_DEPTH-1] == SENT), "expired track not cleared")
  `THMS_ASSERT_NEXT(a_miss_shifts_sentinel, a_fire && !a_start_r && !a_det_r, (hist_x_r[0] == SENT) && (hist_y_r[0] == SENT), "miss frame left a position in the history")
  `THMS_ASSERT_NEXT(a_start_resets_misses, a_fire && a_start_r, miss_r <= MISS_W'(1), "start frame kept old miss count")
  `THMS_ASSERT_NEXT(a_result_follows_work, a_fire, out_vld_r, "processed transaction produced no result")

endmodule

`default_nettype wire
